@@ design/source_code_tokenizer_macros.svh @@
// ---------------------------------------------------------------------------
// source_code_tokenizer_macros.svh
// Assertion macros for the tokenizer RTL.
// ---------------------------------------------------------------------------
`ifndef SOURCE_CODE_TOKENIZER_MACROS_SVH
`define SOURCE_CODE_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sct_pkg.sv @@
// ---------------------------------------------------------------------------
// sct_pkg
// Types, codes and byte classes for the source code tokenizer.
// ---------------------------------------------------------------------------
package sct_pkg;

  typedef enum logic [3:0] {
    KIND_OP      = 4'd0,
    KIND_SYM     = 4'd1,
    KIND_NUM     = 4'd2,
    KIND_NUM_ERR = 4'd3,
    KIND_HEX     = 4'd4,
    KIND_HEX_ERR = 4'd5,
    KIND_STR     = 4'd6,
    KIND_STR_ERR = 4'd7,
    KIND_CHR     = 4'd8,
    KIND_CHR_ERR = 4'd9,
    KIND_UNK     = 4'd10,
    KIND_UNCL    = 4'd11,
    KIND_EOF     = 4'd12
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_TAIL   = 4'd1,
    PH_LINE   = 4'd2,
    PH_BOPEN  = 4'd3,
    PH_BLOCK  = 4'd4,
    PH_SYMBOL = 4'd5,
    PH_NUMBER = 4'd6,
    PH_HEXX   = 4'd7,
    PH_HEX    = 4'd8,
    PH_STRING = 4'd9,
    PH_CBODY  = 4'd10,
    PH_CESC   = 4'd11,
    PH_CCLOSE = 4'd12
  } phase_t;

  // Step within one queued item.
  typedef enum logic [1:0] {
    SUB_HELD = 2'd0,
    SUB_LAST = 2'd1,
    SUB_FIN  = 2'd2,
    SUB_EOF  = 2'd3
  } sub_t;

  // Literal flags.
  localparam logic [4:0] F_DOT   = 5'b00001;
  localparam logic [4:0] F_NEED  = 5'b00010;
  localparam logic [4:0] F_AFTE  = 5'b00100;
  localparam logic [4:0] F_FIRST = 5'b01000;
  localparam logic [4:0] F_ESC   = 5'b10000;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;

  // Entry passed from the front to the back.
  typedef struct packed {
    logic       held_vld;
    logic [7:0] held;
    logic [7:0] cur;
    logic       fin;
  } entry_t;

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_let(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_symc(input logic [7:0] c);
    return is_let(c) || is_dig(c) || c == CH_UNDER;
  endfunction

  function automatic logic is_hexd(input logic [7:0] c);
    return is_dig(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09 ||
           c == 8'h08 || c == 8'h0B || c == 8'h0C;
  endfunction

  function automatic logic is_opc(input logic [7:0] c);
    return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F || c == 8'h5E ||
           c == 8'h3C || c == 8'h3E || c == 8'h3D || c == 8'h2C || c == 8'h21 ||
           c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D || c == 8'h7B ||
           c == 8'h7D || c == 8'h25 || c == 8'h3A || c == 8'h3F || c == 8'h26 ||
           c == 8'h7C || c == 8'h3B || c == 8'h2E;
  endfunction

endpackage

@@ design/sct_if.sv @@
// ---------------------------------------------------------------------------
// sct_if
// Valid/ready channels for source bytes and token records.
// ---------------------------------------------------------------------------
interface sct_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       is_final;

  modport source (output valid, source_byte, is_final, input ready);
  modport sink   (input valid, source_byte, is_final, output ready);
endinterface

interface sct_token_if #(
  parameter int OFFSET_BITS = 20,
  parameter int LINE_BITS   = 16
);
  logic                   valid;
  logic                   ready;
  logic [3:0]             token_kind;
  logic [OFFSET_BITS-1:0] token_start;
  logic [OFFSET_BITS-1:0] token_length;
  logic [LINE_BITS-1:0]   token_line;
  logic [LINE_BITS-1:0]   token_column;
  logic                   last_of_run;

  modport source (output valid, token_kind, token_start, token_length, token_line,
                  token_column, last_of_run, input ready);
  modport sink   (input valid, token_kind, token_start, token_length, token_line,
                  token_column, last_of_run, output ready);
endinterface

@@ design/sct_front.sv @@
// ---------------------------------------------------------------------------
// sct_front
// Accept bytes, pair each held byte with its lookahead, build queue entries.
// ---------------------------------------------------------------------------
module sct_front import sct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_fin,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_entry
);

  logic       held_vld_r, held_vld_nxt;
  logic [7:0] held_r, held_nxt;
  logic       acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // A byte with nothing held and no end mark only gets held.
  assign q_push           = acc && (held_vld_r || in_fin);
  assign q_entry.held_vld = held_vld_r;
  assign q_entry.held     = held_r;
  assign q_entry.cur      = in_byte;
  assign q_entry.fin      = in_fin;

  always_comb begin
    held_vld_nxt = held_vld_r;
    held_nxt     = held_r;
    if (acc) begin
      held_vld_nxt = !in_fin;
      held_nxt     = in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r <= 1'b0;
      held_r     <= '0;
    end else begin
      held_vld_r <= held_vld_nxt;
      held_r     <= held_nxt;
    end
  end

endmodule

@@ design/sct_queue.sv @@
// ---------------------------------------------------------------------------
// sct_queue
// Two-entry queue between the front and the back.
// ---------------------------------------------------------------------------
module sct_queue import sct_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  entry_t     mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/sct_back.sv @@
// ---------------------------------------------------------------------------
// sct_back
// Lexer: a byte or closing step per cycle unless stalled; token register out.
// ---------------------------------------------------------------------------
`include "source_code_tokenizer_macros.svh"

module sct_back import sct_pkg::*; #(
  parameter int OFFSET_BITS = 20,
  parameter int LINE_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  entry_t                 q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             out_kind,
  output logic [OFFSET_BITS-1:0] out_start,
  output logic [OFFSET_BITS-1:0] out_length,
  output logic [LINE_BITS-1:0]   out_line,
  output logic [LINE_BITS-1:0]   out_column,
  output logic                   out_last
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LIN_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

  phase_t                 phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] pstart_r, pstart_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [LINE_BITS-1:0]   col_r, col_nxt;
  logic [4:0]             flags_r, flags_nxt;
  sub_t                   sub_r, sub_nxt;

  logic                   ov_r;
  logic [3:0]             kind_r;
  logic [OFFSET_BITS-1:0] start_r, len_r;
  logic [LINE_BITS-1:0]   tline_r, tcol_r;
  logic                   last_r;

  sub_t                   sub_eff;
  logic                   step;
  logic [7:0]             h, n;
  logic                   hn;
  logic [OFFSET_BITS-1:0] nx, nx2;
  logic [LINE_BITS-1:0]   pc_line, pc_col, pc_col2;
  phase_t                 pc_phase;
  logic [OFFSET_BITS-1:0] pc_pstart;
  logic [4:0]             pc_flags, f;
  logic                   num_go, num_done, more, two;
  logic                   em;
  kind_t                  em_kind;
  logic [OFFSET_BITS-1:0] em_start, em_end;
  logic [LINE_BITS-1:0]   em_col;
  logic                   tok, tok_last;

  assign sub_eff = (sub_r == SUB_HELD && !q_head.held_vld) ? SUB_LAST : sub_r;
  assign step    = !q_empty && (!ov_r || out_ready);
  assign h       = (sub_eff == SUB_HELD) ? q_head.held : q_head.cur;
  assign n       = q_head.cur;
  assign hn      = sub_eff == SUB_HELD;
  assign nx      = (off_r == OFF_MAX) ? off_r : off_r + 1'b1;
  assign nx2     = (nx == OFF_MAX) ? nx : nx + 1'b1;

  // One byte through the lexer.
  always_comb begin
    pc_line   = line_r;
    pc_col    = col_r;
    pc_phase  = phase_r;
    pc_pstart = pstart_r;
    pc_flags  = flags_r;
    f         = flags_r;
    num_go    = 1'b0;
    num_done  = 1'b0;
    more      = 1'b0;
    two       = 1'b0;
    em        = 1'b0;
    em_kind   = KIND_OP;
    em_start  = off_r;
    em_end    = nx;
    if (h == CH_NL) begin
      pc_line = (line_r == LIN_MAX) ? line_r : line_r + 1'b1;
      pc_col  = '0;
    end else begin
      pc_col = (col_r == LIN_MAX) ? col_r : col_r + 1'b1;
    end
    pc_col2 = (pc_col == LIN_MAX) ? pc_col : pc_col + 1'b1;
    em_col  = pc_col;

    unique case (phase_r)
      PH_TAIL:  pc_phase = PH_IDLE;
      PH_LINE:  if (h == CH_NL) pc_phase = PH_IDLE;
      PH_BOPEN: pc_phase = PH_BLOCK;
      PH_BLOCK: if (h == CH_STAR && hn && n == CH_SLASH) pc_phase = PH_TAIL;
      PH_SYMBOL: begin
        if (!(hn && is_symc(n))) begin
          em = 1'b1; em_kind = KIND_SYM; em_start = pstart_r;
          pc_phase = PH_IDLE;
        end
      end
      PH_NUMBER: num_go = 1'b1;
      PH_HEXX: begin
        if (hn && is_hexd(n)) begin
          pc_phase = PH_HEX;
        end else begin
          em = 1'b1; em_kind = KIND_HEX_ERR; em_start = pstart_r;
          pc_phase = PH_IDLE;
        end
      end
      PH_HEX: begin
        if (!(hn && is_hexd(n))) begin
          em = 1'b1; em_kind = KIND_HEX; em_start = pstart_r;
          pc_phase = PH_IDLE;
        end
      end
      PH_STRING: begin
        if ((flags_r & F_ESC) != '0) begin
          pc_flags = flags_r & ~F_ESC;
        end else if (h == CH_BSL) begin
          pc_flags = flags_r | F_ESC;
        end else if (h == CH_DQ) begin
          em = 1'b1; em_kind = KIND_STR; em_start = pstart_r; em_end = off_r;
          pc_flags = '0;
          pc_phase = PH_IDLE;
        end
      end
      PH_CBODY: pc_phase = (h == CH_BSL) ? PH_CESC : PH_CCLOSE;
      PH_CESC:  pc_phase = PH_CCLOSE;
      PH_CCLOSE: begin
        em = 1'b1; em_kind = (h == CH_SQ) ? KIND_CHR : KIND_CHR_ERR;
        em_start = pstart_r; em_end = off_r;
        pc_phase = PH_IDLE;
      end
      default: begin
        pc_phase = PH_IDLE;
        two = hn && ((n == CH_EQ && (h == CH_LT || h == CH_GT || h == CH_BANG ||
                                     h == CH_EQ)) ||
                     (h == CH_LT && n == CH_LT) || (h == CH_GT && n == CH_GT) ||
                     (h == CH_STAR && n == CH_STAR));
        if (is_ws(h)) begin
          pc_phase = PH_IDLE;
        end else if (h == CH_SLASH && hn && n == CH_SLASH) begin
          pc_pstart = off_r; pc_phase = PH_LINE;
        end else if (h == CH_SLASH && hn && n == CH_STAR) begin
          pc_pstart = off_r; pc_phase = PH_BOPEN;
        end else if (is_opc(h)) begin
          if (two) begin
            em = 1'b1; em_end = nx2; em_col = pc_col2;
            pc_phase = PH_TAIL;
          end else if (h == CH_MINUS && hn && is_dig(n)) begin
            pc_pstart = off_r; pc_flags = F_FIRST; pc_phase = PH_NUMBER;
          end else begin
            em = 1'b1;
          end
        end else if (is_let(h) || h == CH_UNDER) begin
          pc_pstart = off_r;
          if (hn && is_symc(n)) pc_phase = PH_SYMBOL;
          else begin
            em = 1'b1; em_kind = KIND_SYM;
          end
        end else if (is_dig(h)) begin
          pc_pstart = off_r; f = F_FIRST; pc_phase = PH_NUMBER; num_go = 1'b1;
        end else if (h == CH_DQ) begin
          pc_pstart = nx; pc_flags = '0; pc_phase = PH_STRING;
        end else if (h == CH_SQ) begin
          pc_pstart = nx; pc_phase = PH_CBODY;
        end else begin
          em = 1'b1; em_kind = KIND_UNK;
        end
      end
    endcase

    // Number body, shared by the first digit and later bytes.
    if (num_go) begin
      em_start = pc_pstart;
      if ((f & F_FIRST) != '0) begin
        f = f & ~F_FIRST;
        if (h == CH_ZERO && hn && n == CH_X) begin
          f = '0; pc_phase = PH_HEXX; num_done = 1'b1;
        end
      end
      if (!num_done) begin
        if ((f & F_AFTE) != '0) begin
          f = f & ~F_AFTE;
          if (is_dig(h)) f = f & ~F_NEED;
        end else if (h == CH_DOT) begin
          f = f | F_DOT;
        end else if (h == CH_E_LO || h == CH_E_UP) begin
          num_done = 1'b1;
          if (!hn || !(n == CH_PLUS || n == CH_MINUS || is_dig(n))) begin
            em = 1'b1; em_kind = KIND_NUM_ERR; pc_phase = PH_IDLE; f = '0;
          end else begin
            f = f | F_NEED | F_AFTE;
          end
        end else if (is_dig(h)) begin
          f = f & ~F_NEED;
        end
      end
      if (!num_done) begin
        more = hn && (is_dig(n) || n == CH_E_LO || n == CH_E_UP ||
                      (n == CH_DOT && (f & F_DOT) == '0));
        if (!more) begin
          em = 1'b1; em_kind = ((f & F_NEED) != '0) ? KIND_NUM_ERR : KIND_NUM;
          pc_phase = PH_IDLE; f = '0;
        end
      end
      pc_flags = f;
    end
  end

  // Step sequencing, closing tokens and state update.
  always_comb begin
    phase_nxt  = phase_r;
    off_nxt    = off_r;
    pstart_nxt = pstart_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    flags_nxt  = flags_r;
    sub_nxt    = sub_r;
    q_pop      = 1'b0;
    tok        = 1'b0;
    tok_last   = 1'b0;
    if (step) begin
      unique case (sub_eff)
        SUB_HELD, SUB_LAST: begin
          phase_nxt  = pc_phase;
          off_nxt    = nx;
          pstart_nxt = pc_pstart;
          line_nxt   = pc_line;
          col_nxt    = pc_col;
          flags_nxt  = pc_flags;
          tok        = em;
          tok_last   = !q_head.fin;
          if (sub_eff == SUB_LAST) sub_nxt = SUB_FIN;
          else if (q_head.fin) sub_nxt = SUB_LAST;
          else q_pop = 1'b1;
        end
        SUB_FIN: begin
          tok     = phase_r == PH_BOPEN || phase_r == PH_BLOCK ||
                    phase_r == PH_STRING || phase_r == PH_CBODY ||
                    phase_r == PH_CESC || phase_r == PH_CCLOSE;
          sub_nxt = SUB_EOF;
        end
        SUB_EOF: begin
          tok        = 1'b1;
          tok_last   = 1'b1;
          q_pop      = 1'b1;
          sub_nxt    = SUB_HELD;
          phase_nxt  = PH_IDLE;
          off_nxt    = '0;
          pstart_nxt = '0;
          line_nxt   = LINE_ONE;
          col_nxt    = '0;
          flags_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      off_r    <= '0;
      pstart_r <= '0;
      line_r   <= LINE_ONE;
      col_r    <= '0;
      flags_r  <= '0;
      sub_r    <= SUB_HELD;
      ov_r     <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      off_r    <= off_nxt;
      pstart_r <= pstart_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      flags_r  <= flags_nxt;
      sub_r    <= sub_nxt;
      if (step) ov_r <= tok;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // Token payload; loads only when the register is free or draining.
  always_ff @(posedge clk) begin
    if (step && tok) begin
      last_r <= tok_last;
      unique case (sub_eff)
        SUB_HELD, SUB_LAST: begin
          kind_r  <= em_kind;
          start_r <= em_start;
          len_r   <= (em_end > em_start) ? em_end - em_start : '0;
          tline_r <= pc_line;
          tcol_r  <= em_col;
        end
        SUB_FIN: begin
          kind_r  <= (phase_r == PH_STRING) ? KIND_STR_ERR :
                     (phase_r == PH_BOPEN || phase_r == PH_BLOCK) ? KIND_UNCL :
                     KIND_CHR_ERR;
          start_r <= pstart_r;
          len_r   <= (off_r > pstart_r) ? off_r - pstart_r : '0;
          tline_r <= line_r;
          tcol_r  <= col_r;
        end
        SUB_EOF: begin
          kind_r  <= KIND_EOF;
          start_r <= off_r;
          len_r   <= '0;
          tline_r <= line_r;
          tcol_r  <= '0;
        end
      endcase
    end
  end

  assign out_valid  = ov_r;
  assign out_kind   = kind_r;
  assign out_start  = start_r;
  assign out_length = len_r;
  assign out_line   = tline_r;
  assign out_column = tcol_r;
  assign out_last   = last_r;

  `SCT_ASSERT_NOW(a_eof_last, ov_r && kind_r == KIND_EOF, last_r && len_r == '0, "eof not last")
  `SCT_ASSERT_NOW(a_close_has_entry, sub_r != SUB_HELD, !q_empty && q_head.fin, "close w/o entry")
  `SCT_ASSERT_NEXT(a_eof_resets, step && sub_eff == SUB_EOF, phase_r == PH_IDLE && line_r == LINE_ONE && off_r == '0, "no reset after eof")

endmodule

@@ design/source_code_tokenizer.sv @@
// ---------------------------------------------------------------------------
// source_code_tokenizer
// Streaming C-style lexer: source bytes in, token records out.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake      Payload
//  in_ch    sink       valid/ready    source_byte, is_final
//  out_ch   source     valid/ready    token_kind, token_start, token_length,
//                                     token_line, token_column, last_of_run
//
//  The engine lexes each queued byte pair; the first byte of a source is
//  only held until its lookahead arrives. A byte marked final runs through
//  the steps held byte, last byte, unclosed-literal check and eof token;
//  the held-byte step is skipped when it is the only byte of its source.
//  The engine is the single shared step unit and sets the rate: one byte a
//  cycle while the queue holds an entry and the token register drains.
//  Reset is synchronous, active low; no clearing pass is needed.
//  A stalled token register stops the engine; the two-entry queue keeps the
//  input side taking bytes until it fills.
// ---------------------------------------------------------------------------
module source_code_tokenizer import sct_pkg::*; #(
  parameter int OFFSET_BITS = 20,
  parameter int LINE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  sct_byte_if.sink    in_ch,
  sct_token_if.source out_ch
);

  // Front to back queue handshake.
  entry_t push_entry, head_entry;
  logic   push, pop, full, empty;

  // Hold each byte until its lookahead arrives, then queue the pair.
  sct_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.source_byte),
    .in_fin   (in_ch.is_final),
    .q_full   (full),
    .q_push   (push),
    .q_entry  (push_entry)
  );

  // Decouple byte intake from token delivery.
  sct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head      (head_entry)
  );

  // Advance the lexer state and drive the token register.
  sct_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (empty),
    .q_head     (head_entry),
    .q_pop      (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_kind   (out_ch.token_kind),
    .out_start  (out_ch.token_start),
    .out_length (out_ch.token_length),
    .out_line   (out_ch.token_line),
    .out_column (out_ch.token_column),
    .out_last   (out_ch.last_of_run)
  );

endmodule

@@ dv/source_code_tokenizer_test.sv @@
// ---------------------------------------------------------------------------
// source_code_tokenizer_test
// Feeds short C-style sources byte by byte into the tokenizer and checks every
// token record against a behavioral lexer kept inside this bench. Directed
// sources cover the edge cases; random ones are built from lexeme snippets
// with noise bytes mixed in. Both handshake sides idle at random, and the
// token side also holds off for a long stretch so that the block backs up.
// ---------------------------------------------------------------------------
module source_code_tokenizer_test import sct_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFF_W = 20;
  localparam int LIN_W = 16;
  localparam int unsigned OFF_MAX = (1 << OFF_W) - 1;
  localparam int unsigned LIN_MAX = (1 << LIN_W) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 160;

  typedef struct {
    kind_t              kind;
    logic [OFF_W-1:0]   start;
    logic [OFF_W-1:0]   length;
    logic [LIN_W-1:0]   line;
    logic [LIN_W-1:0]   column;
    logic               last;
  } token_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sct_byte_if in_ch();
  sct_token_if #(.OFFSET_BITS(OFF_W), .LINE_BITS(LIN_W)) out_ch();

  source_code_tokenizer #(.OFFSET_BITS(OFF_W), .LINE_BITS(LIN_W)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // Tokens the lexer model has predicted and the block has not yet produced.
  token_rec_t expected_tokens[$];
  token_rec_t step_tokens[$];

  int mismatches = 0;
  int tokens_checked = 0;
  int bytes_sent = 0;
  int sources_sent = 0;
  int cycle_count = 0;
  bit calm_mode = 1'b0;       // no idling on either side while set
  int holdoff_cycles = 0;     // receiver stall requested by a test

  // ---------------------------------------------------------------------------
  // Lexer model state
  // ---------------------------------------------------------------------------
  phase_t           lx_phase;
  logic [7:0]       lx_held;
  bit               lx_held_vld;
  int unsigned      lx_off;
  int unsigned      lx_pend;
  int unsigned      lx_line;
  int unsigned      lx_col;
  logic [4:0]       lx_flags;

  function automatic int unsigned sat_up(int unsigned v, int unsigned mx);
    return (v >= mx) ? mx : v + 1;
  endfunction

  function automatic bit c_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit c_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit c_word(logic [7:0] c);
    return c_alpha(c) || c_digit(c) || c == CH_UNDER;
  endfunction

  function automatic bit c_hex(logic [7:0] c);
    return c_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit c_space(logic [7:0] c);
    return c == " " || c == CH_NL || c == 8'h0D || c == 8'h09 ||
           c == 8'h08 || c == 8'h0B || c == 8'h0C;
  endfunction

  function automatic bit c_oper(logic [7:0] c);
    case (c)
      "+", "-", "*", "/", "^", "<", ">", "=", ",", "!", "(", ")", "[", "]",
      "{", "}", "%", ":", "?", "&", "|", ";", ".": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void lexer_reset();
    lx_phase = PH_IDLE;
    lx_held = '0;
    lx_held_vld = 1'b0;
    lx_off = 0;
    lx_pend = 0;
    lx_line = 1;
    lx_col = 0;
    lx_flags = '0;
  endfunction

  function automatic void record_token(kind_t k, int unsigned s, int unsigned ex,
                                       int unsigned col);
    token_rec_t t;
    if (step_tokens.size() >= 3) return;
    t.kind = k;
    t.start = s[OFF_W-1:0];
    t.length = (ex > s) ? OFF_W'(ex - s) : '0;
    t.line = lx_line[LIN_W-1:0];
    t.column = col[LIN_W-1:0];
    t.last = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void number_step(logic [7:0] h, logic [7:0] n, bit has_n,
                                      int unsigned nx);
    bit more;
    if (lx_flags & F_FIRST) begin
      lx_flags &= ~F_FIRST;
      if (h == CH_ZERO && has_n && n == CH_X) begin
        lx_flags = '0;
        lx_phase = PH_HEXX;
        return;
      end
    end
    if (lx_flags & F_AFTE) begin
      lx_flags &= ~F_AFTE;
      if (c_digit(h)) lx_flags &= ~F_NEED;
    end else if (h == CH_DOT) begin
      lx_flags |= F_DOT;
    end else if (h == CH_E_LO || h == CH_E_UP) begin
      if (!has_n || !(n == CH_PLUS || n == CH_MINUS || c_digit(n))) begin
        record_token(KIND_NUM_ERR, lx_pend, nx, lx_col);
        lx_phase = PH_IDLE;
        lx_flags = '0;
        return;
      end
      lx_flags |= F_NEED | F_AFTE;
      return;
    end else if (c_digit(h)) begin
      lx_flags &= ~F_NEED;
    end
    more = has_n && (c_digit(n) || n == CH_E_LO || n == CH_E_UP ||
                     (n == CH_DOT && !(lx_flags & F_DOT)));
    if (!more) begin
      record_token((lx_flags & F_NEED) ? KIND_NUM_ERR : KIND_NUM, lx_pend, nx, lx_col);
      lx_phase = PH_IDLE;
      lx_flags = '0;
    end
  endfunction

  function automatic void idle_step(logic [7:0] h, logic [7:0] n, bit has_n,
                                    int unsigned off, int unsigned nx);
    bit pair;
    if (c_space(h)) return;
    if (h == CH_SLASH && has_n && n == CH_SLASH) begin
      lx_pend = off;
      lx_phase = PH_LINE;
    end else if (h == CH_SLASH && has_n && n == CH_STAR) begin
      lx_pend = off;
      lx_phase = PH_BOPEN;
    end else if (c_oper(h)) begin
      pair = has_n && ((n == CH_EQ && (h == CH_LT || h == CH_GT || h == CH_BANG ||
                        h == CH_EQ)) || (h == CH_LT && n == CH_LT) ||
                       (h == CH_GT && n == CH_GT) || (h == CH_STAR && n == CH_STAR));
      if (pair) begin
        record_token(KIND_OP, off, sat_up(nx, OFF_MAX), sat_up(lx_col, LIN_MAX));
        lx_phase = PH_TAIL;
      end else if (h == CH_MINUS && has_n && c_digit(n)) begin
        lx_pend = off;
        lx_flags = F_FIRST;
        lx_phase = PH_NUMBER;
      end else begin
        record_token(KIND_OP, off, nx, lx_col);
      end
    end else if (c_alpha(h) || h == CH_UNDER) begin
      lx_pend = off;
      if (has_n && c_word(n)) lx_phase = PH_SYMBOL;
      else record_token(KIND_SYM, off, nx, lx_col);
    end else if (c_digit(h)) begin
      lx_pend = off;
      lx_flags = F_FIRST;
      lx_phase = PH_NUMBER;
      number_step(h, n, has_n, nx);
    end else if (h == CH_DQ) begin
      lx_pend = nx;
      lx_flags = '0;
      lx_phase = PH_STRING;
    end else if (h == CH_SQ) begin
      lx_pend = nx;
      lx_phase = PH_CBODY;
    end else begin
      record_token(KIND_UNK, off, nx, lx_col);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] h, logic [7:0] n, bit has_n);
    int unsigned off;
    int unsigned nx;
    off = lx_off;
    nx = sat_up(off, OFF_MAX);
    if (h == CH_NL) begin
      lx_line = sat_up(lx_line, LIN_MAX);
      lx_col = 0;
    end else begin
      lx_col = sat_up(lx_col, LIN_MAX);
    end
    case (lx_phase)
      PH_TAIL:  lx_phase = PH_IDLE;
      PH_LINE:  if (h == CH_NL) lx_phase = PH_IDLE;
      PH_BOPEN: lx_phase = PH_BLOCK;
      PH_BLOCK: if (h == CH_STAR && has_n && n == CH_SLASH) lx_phase = PH_TAIL;
      PH_SYMBOL:
        if (!(has_n && c_word(n))) begin
          record_token(KIND_SYM, lx_pend, nx, lx_col);
          lx_phase = PH_IDLE;
        end
      PH_NUMBER: number_step(h, n, has_n, nx);
      PH_HEXX:
        if (has_n && c_hex(n)) begin
          lx_phase = PH_HEX;
        end else begin
          record_token(KIND_HEX_ERR, lx_pend, nx, lx_col);
          lx_phase = PH_IDLE;
        end
      PH_HEX:
        if (!(has_n && c_hex(n))) begin
          record_token(KIND_HEX, lx_pend, nx, lx_col);
          lx_phase = PH_IDLE;
        end
      PH_STRING:
        if (lx_flags & F_ESC) begin
          lx_flags &= ~F_ESC;
        end else if (h == CH_BSL) begin
          lx_flags |= F_ESC;
        end else if (h == CH_DQ) begin
          record_token(KIND_STR, lx_pend, off, lx_col);
          lx_flags = '0;
          lx_phase = PH_IDLE;
        end
      PH_CBODY:  lx_phase = (h == CH_BSL) ? PH_CESC : PH_CCLOSE;
      PH_CESC:   lx_phase = PH_CCLOSE;
      PH_CCLOSE: begin
        record_token((h == CH_SQ) ? KIND_CHR : KIND_CHR_ERR, lx_pend, off, lx_col);
        lx_phase = PH_IDLE;
      end
      default: begin
        lx_phase = PH_IDLE;
        idle_step(h, n, has_n, off, nx);
      end
    endcase
    lx_off = nx;
  endfunction

  // Work out the tokens caused by one accepted byte and queue them.
  function automatic void predict_tokens(logic [7:0] b, bit fin);
    step_tokens.delete();
    if (lx_held_vld) lex_byte(lx_held, b, 1'b1);
    if (fin) begin
      lex_byte(b, 8'h00, 1'b0);
      if (lx_phase == PH_BOPEN || lx_phase == PH_BLOCK)
        record_token(KIND_UNCL, lx_pend, lx_off, lx_col);
      else if (lx_phase == PH_STRING)
        record_token(KIND_STR_ERR, lx_pend, lx_off, lx_col);
      else if (lx_phase == PH_CBODY || lx_phase == PH_CESC || lx_phase == PH_CCLOSE)
        record_token(KIND_CHR_ERR, lx_pend, lx_off, lx_col);
      record_token(KIND_EOF, lx_off, lx_off, 0);
      lexer_reset();
    end else begin
      lx_held = b;
      lx_held_vld = 1'b1;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.source_byte = '0;
    in_ch.is_final = 1'b0;
    out_ch.ready = 1'b0;
  end

  task automatic send_byte(logic [7:0] b, bit fin);
    // Drop valid for a short random gap now and then.
    if (!calm_mode && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.source_byte <= b;
    in_ch.is_final <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_tokens(b, fin);
    bytes_sent++;
  endtask

  task automatic send_source(string text);
    for (int i = 0; i < text.len(); i++) send_byte(text[i], i == text.len() - 1);
    sources_sent++;
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and hold until every predicted token is out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Token receiver: random stalls, a requested long hold-off, calm stretches
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (holdoff_cycles > 0) begin
      out_ch.ready <= 1'b0;
      holdoff_cycles--;
    end else if (calm_mode) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 20);
    end
  end

  // Compare each accepted token with the oldest prediction.
  always @(posedge clk) begin
    token_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected token kind=%0d start=%0d", $realtime,
                   out_ch.token_kind, out_ch.token_start);
      end else begin
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (out_ch.token_kind !== want.kind || out_ch.token_start !== want.start ||
            out_ch.token_length !== want.length || out_ch.token_line !== want.line ||
            out_ch.token_column !== want.column || out_ch.last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] token mismatch: exp k=%0d s=%0d l=%0d ln=%0d c=%0d last=%0b",
                     $realtime, want.kind, want.start, want.length, want.line,
                     want.column, want.last,
                     "\n                     got k=%0d s=%0d l=%0d ln=%0d c=%0d last=%0b",
                     out_ch.token_kind, out_ch.token_start, out_ch.token_length,
                     out_ch.token_line, out_ch.token_column, out_ch.last_of_run);
        end
      end
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding", cycle_count,
               expected_tokens.size());
      $display("** source_code_tokenizer: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Edge cases: two-byte operator, negative number, hex error, exponent with
  // nothing after it, signed exponent, char left open, block comment left
  // open, and a lone high byte as an unknown token.
  task automatic test_directed_lexemes();
    send_source("_z>=0xg 1e");
    send_source("-7.5E+3'a");
    send_source("/*");
    send_source(string'(8'hFF));
    wait_drained();
  endtask

  // Random sources assembled from lexeme snippets, some malformed, with noise mixed in.
  task automatic test_random_sources();
    string pieces[] = '{"abc", "x_9", "42", "3.14", "6.02e23", "1e-9", "2E+", "7e",
                        "0x1f", "0xZ", "-12", "\"hi\\\"x\"", "\"a b\"", "'c'",
                        "'\\n'", "'ab'", "// note\n", "/* c */", "<<", ">>", "==",
                        "!=", "**", "!", "(", ";", ".", "@", "\n", "\t", "\"open",
                        "/* open", "'"};
    string text;
    int start_bytes;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      text = "";
      repeat ($urandom_range(6, 1)) begin
        if ($urandom_range(99) < 15)
          text = {text, string'(8'($urandom_range(255)))};
        else
          text = {text, pieces[$urandom_range(pieces.size() - 1)]};
        if ($urandom_range(1)) text = {text, " "};
      end
      // Hold calm for a run of sources so that no gaps appear at all.
      calm_mode = (sources_sent % 12 >= 8);
      send_source(text);
    end
    calm_mode = 1'b0;
    wait_drained();
  endtask

  // Stall the token side for a long time while bytes keep coming.
  task automatic test_output_holdoff();
    holdoff_cycles = 200;
    send_source("a+b*c==d<<2 x;");
    wait_drained();
  endtask

  // Pause the byte side until every token is out, then carry on.
  task automatic test_input_pause();
    send_byte("q", 1'b0);
    send_byte("1", 1'b0);
    idle_input();
    // The held byte gives a token only once the next byte arrives.
    wait_drained();
    repeat (20) @(posedge clk);
    send_byte("\"", 1'b1);
    sources_sent++;
    wait_drained();
  endtask

  initial begin
    lexer_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_lexemes();
    test_output_holdoff();
    test_input_pause();
    test_random_sources();
    idle_input();
    wait_drained();
    repeat (30) @(posedge clk);
    $display("covered %0d sources, %0d bytes, %0d tokens checked, %0d mismatches",
             sources_sent, bytes_sent, tokens_checked, mismatches);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("** source_code_tokenizer: PASSED **");
    end else begin
      $display("%0d tokens never arrived", expected_tokens.size());
      $display("** source_code_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule

@@ source_code_tokenizer.f @@
+incdir+design
design/sct_pkg.sv
design/sct_if.sv
design/sct_front.sv
design/sct_queue.sv
design/sct_back.sv
design/source_code_tokenizer.sv
dv/source_code_tokenizer_test.sv
